// ===== sv/amdfs_pkg.sv =====
// Shared types and codes for the adjacency matrix depth-first search block.
package amdfs_pkg;

    localparam int VERTEX_W = 6;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DFS   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_VISIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } req_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } rsp_item_t;

    // Address source for the adjacency row port
    typedef enum logic [1:0] {
        ROW_A,
        ROW_B,
        ROW_STK,
        ROW_HIT
    } row_sel_t;

    typedef struct packed {
        logic              load;
        logic              clr_rows;
        logic              row_rd;
        logic              row_wr;
        row_sel_t          row_sel;
        logic              dfs_init;
        logic              stk_rd;
        logic              push;
        logic              pop;
        logic              flush;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            a_ok;
        logic            b_ok;
        logic            found;
        logic            depth_one;
        logic            out_free;
    } dp_status_t;

endpackage

// ===== sv/adjacency_matrix_dfs.sv =====
// Undirected graph held as a bit adjacency matrix with edge insert, clear and
// depth-first search. One request is in work at a time; a new one is taken once
// the previous one has loaded its last result. Edge insert does a read-modify-
// write of both rows on the single row port. Clear drops all row valid bits at
// once. A search reads the start vertex row, then for each descent to a new
// vertex pushes it and fetches its row together; each return to a parent pops,
// reads the stack and then reads the parent row, and the search ends by popping
// the start vertex and handing over the last result. A stalled output holds the
// search until the slot frees.
module adjacency_matrix_dfs
    import amdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_item_t          req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_item_t          rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    amdfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    amdfs_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== sv/amdfs_ctrl.sv =====
// Sequencing state machine for edge insert, clear and depth-first search.
module amdfs_ctrl
    import amdfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD_A,
        S_EDGE_WR_A,
        S_EDGE_RD_B,
        S_EDGE_WR_B,
        S_EMIT_EDGE,
        S_EMIT_RANGE,
        S_EMIT_CLEAR,
        S_DFS_START,
        S_SCAN,
        S_STK_RD,
        S_ROW_RD,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.row_sel   = ROW_A;
        cmd.emit_kind = KIND_EDGE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (status.op)
                        OP_EDGE:
                        begin
                            if (status.a_ok && status.b_ok)
                                state_next = S_EDGE_RD_A;
                            else
                                state_next = S_EMIT_RANGE;
                        end
                        OP_DFS:
                        begin
                            if (status.a_ok)
                                state_next = S_DFS_START;
                            else
                                state_next = S_EMIT_RANGE;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clr_rows = 1'b1;
                            state_next   = S_EMIT_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE_RD_A:
            begin
                cmd.row_rd  = 1'b1;
                cmd.row_sel = ROW_A;
                state_next  = S_EDGE_WR_A;
            end
            S_EDGE_WR_A:
            begin
                cmd.row_wr  = 1'b1;
                cmd.row_sel = ROW_A;
                state_next  = S_EDGE_RD_B;
            end
            S_EDGE_RD_B:
            begin
                cmd.row_rd  = 1'b1;
                cmd.row_sel = ROW_B;
                state_next  = S_EDGE_WR_B;
            end
            S_EDGE_WR_B:
            begin
                cmd.row_wr  = 1'b1;
                cmd.row_sel = ROW_B;
                state_next  = S_EMIT_EDGE;
            end
            S_EMIT_EDGE, S_EMIT_RANGE, S_EMIT_CLEAR:
            begin
                if (state_reg == S_EMIT_RANGE)
                    cmd.emit_kind = KIND_RANGE;
                else if (state_reg == S_EMIT_CLEAR)
                    cmd.emit_kind = KIND_CLEARED;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DFS_START:
            begin
                cmd.dfs_init = 1'b1;
                cmd.row_rd   = 1'b1;
                cmd.row_sel  = ROW_A;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.found)
                begin
                    // descend: row of the new vertex is fetched in the same cycle
                    if (status.out_free)
                    begin
                        cmd.push    = 1'b1;
                        cmd.row_rd  = 1'b1;
                        cmd.row_sel = ROW_HIT;
                    end
                end
                else
                begin
                    cmd.pop = 1'b1;
                    if (status.depth_one)
                        state_next = S_FLUSH;
                    else
                        state_next = S_STK_RD;
                end
            end
            S_STK_RD:
            begin
                cmd.stk_rd = 1'b1;
                state_next = S_ROW_RD;
            end
            S_ROW_RD:
            begin
                cmd.row_rd  = 1'b1;
                cmd.row_sel = ROW_STK;
                state_next  = S_SCAN;
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/amdfs_datapath.sv =====
// Adjacency rows, visit marks, walk stack, result buffering and output register.
module amdfs_datapath
    import amdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    input  req_item_t          req,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_item_t          rsp
);

    localparam int MV = MAX_VERTICES;
    localparam int AW = (MV > 1) ? $clog2(MV) : 1;
    localparam int DW = AW + 1;

    // row storage: valid bit per row, invalid rows read as zero
    logic [MV-1:0] row_mem [MV];
    logic [AW-1:0] stk_mem [MV];

    logic [COUNT_W-1:0]  vcount_reg, vcount_next;
    logic [MV-1:0]       row_valid_reg, row_valid_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [MV-1:0]       rd_row_reg;
    logic [AW-1:0]       stk_q_reg;
    logic [MV-1:0]       visited_reg, visited_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic                pend_valid_reg, pend_valid_next;
    rsp_item_t           pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg, rsp_next;
    logic [VERTEX_W-1:0] a_reg, b_reg;

    logic [COUNT_W-1:0]  n_lim;
    logic [MV-1:0]       lim_mask;
    logic [MV-1:0]       eff_row;
    logic [MV-1:0]       cand;
    logic                found;
    logic [AW-1:0]       hit_idx;
    logic [AW-1:0]       a_idx, b_idx;
    logic [AW-1:0]       row_addr;
    logic [MV-1:0]       wr_data;
    logic [DW-1:0]       top_ptr;
    logic                stk_we;
    logic [AW-1:0]       stk_waddr;
    logic [AW-1:0]       stk_wdata;
    logic                out_free;

    assign n_lim = (vcount_reg > COUNT_W'(MV)) ? COUNT_W'(MV) : vcount_reg;

    always_comb
    begin
        for (int i = 0; i < MV; i++)
            lim_mask[i] = (COUNT_W'(i) < n_lim);
    end

    assign a_idx   = a_reg[AW-1:0];
    assign b_idx   = b_reg[AW-1:0];
    assign eff_row = rd_valid_reg ? rd_row_reg : '0;

    // neighbors below the current scan point are all visited already,
    // so the lowest unvisited neighbor is the next one in scan order
    assign cand  = eff_row & ~visited_reg & lim_mask;
    assign found = |cand;

    always_comb
    begin
        hit_idx = '0;
        for (int i = MV - 1; i >= 0; i--)
        begin
            if (cand[i])
                hit_idx = AW'(i);
        end
    end

    always_comb
    begin
        unique case (cmd.row_sel)
            ROW_A:   row_addr = a_idx;
            ROW_B:   row_addr = b_idx;
            ROW_STK: row_addr = stk_q_reg;
            ROW_HIT: row_addr = hit_idx;
            default: row_addr = a_idx;
        endcase
    end

    assign wr_data = eff_row | (MV'(1) << ((cmd.row_sel == ROW_A) ? b_idx : a_idx));

    assign top_ptr   = depth_reg - DW'(1);
    assign stk_we    = cmd.dfs_init || cmd.push;
    assign stk_waddr = cmd.dfs_init ? '0 : depth_reg[AW-1:0];
    assign stk_wdata = cmd.dfs_init ? a_idx : hit_idx;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign status.op        = req.op;
    assign status.a_ok      = ({1'b0, req.vertex_a} < n_lim);
    assign status.b_ok      = ({1'b0, req.vertex_b} < n_lim);
    assign status.found     = found;
    assign status.depth_one = (depth_reg == DW'(1));
    assign status.out_free  = out_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        vcount_next     = cfg_we ? cfg_data : vcount_reg;
        row_valid_next  = row_valid_reg;
        rd_valid_next   = rd_valid_reg;
        visited_next    = visited_reg;
        depth_next      = depth_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        if (cmd.clr_rows)
            row_valid_next = '0;
        if (cmd.row_wr)
            row_valid_next[row_addr] = 1'b1;
        if (cmd.row_rd)
            rd_valid_next = row_valid_reg[row_addr];

        if (cmd.dfs_init)
        begin
            visited_next    = MV'(1) << a_idx;
            depth_next      = DW'(1);
            pend_valid_next = 1'b1;
            pend_next       = '{kind: KIND_VISIT, vertex: a_reg, last: 1'b0};
        end
        if (cmd.push)
        begin
            visited_next   = visited_reg | (MV'(1) << hit_idx);
            depth_next     = depth_reg + DW'(1);
            rsp_valid_next = 1'b1;
            rsp_next       = pend_reg;
            rsp_next.last  = 1'b0;
            pend_next      = '{kind: KIND_VISIT, vertex: VERTEX_W'(hit_idx), last: 1'b0};
        end
        if (cmd.pop)
            depth_next = top_ptr;
        if (cmd.flush)
        begin
            rsp_valid_next  = 1'b1;
            rsp_next        = pend_reg;
            rsp_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{kind: cmd.emit_kind, vertex: '0, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= '0;
            row_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            vcount_reg     <= vcount_next;
            row_valid_reg  <= row_valid_next;
            rd_valid_reg   <= rd_valid_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
        if (cmd.load)
        begin
            a_reg <= req.vertex_a;
            b_reg <= req.vertex_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_wr)
            row_mem[row_addr] <= wr_data;
        if (cmd.row_rd)
            rd_row_reg <= row_mem[row_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (cmd.stk_rd)
            stk_q_reg <= stk_mem[top_ptr[AW-1:0]];
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MV))
        else $error("walk stack depth beyond vertex limit");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (pend_valid_reg && out_free))
        else $error("descent without a buffered visit or a free output slot");

    a_final_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush || cmd.emit) |-> out_free)
        else $error("final result loaded into a busy output register");

    a_visit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> ($countones(visited_reg) == $past($countones(visited_reg)) + 1))
        else $error("descent did not mark exactly one new vertex");

endmodule

// ===== tb/sv/tb_adjacency_matrix_dfs.sv =====
// Testbench for adjacency_matrix_dfs: random-timed transfers checked against a graph walk model.
module tb_adjacency_matrix_dfs;
    import amdfs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 300;

    typedef struct {
        req_item_t item;
        bit        drain_first;   // hold this one back until all results are in
    } backlog_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_item_t          req = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_item_t          rsp;

    backlog_entry_t     req_backlog[$];
    rsp_item_t          awaited_rsp[$];
    logic [63:0]        graph_rows[64];
    logic [COUNT_W-1:0] vertex_limit = '0;
    int unsigned        mismatches = 0;
    int unsigned        cycles = 0;
    logic               req_fired = 1'b0;
    int unsigned        send_gap = 0;
    int unsigned        stall_left = 0;
    bit                 send_calm = 0;
    bit                 recv_calm = 0;

    adjacency_matrix_dfs dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Works out the results of one accepted request and updates the graph copy.
    function automatic void walk_graph(input req_item_t it);
        rsp_item_t   found[$];
        rsp_item_t   one;
        logic [63:0] seen;
        logic [5:0]  stk_vertex[64];
        int unsigned stk_next[64];
        int unsigned n;
        int unsigned depth;
        int unsigned w;
        logic [5:0]  v;
        n = (vertex_limit > 64) ? 64 : vertex_limit;
        one = '0;
        case (it.op)
            OP_EDGE:
            begin
                if (it.vertex_a >= n || it.vertex_b >= n)
                begin
                    one.kind = KIND_RANGE;
                end
                else
                begin
                    graph_rows[it.vertex_a][it.vertex_b] = 1'b1;
                    graph_rows[it.vertex_b][it.vertex_a] = 1'b1;
                    one.kind = KIND_EDGE;
                end
                found.push_back(one);
            end
            OP_DFS:
            begin
                if (it.vertex_a >= n)
                begin
                    one.kind = KIND_RANGE;
                    found.push_back(one);
                end
                else
                begin
                    seen = '0;
                    seen[it.vertex_a] = 1'b1;
                    one.kind = KIND_VISIT;
                    one.vertex = it.vertex_a;
                    found.push_back(one);
                    stk_vertex[0] = it.vertex_a;
                    stk_next[0] = 0;
                    depth = 1;
                    while (depth > 0)
                    begin
                        v = stk_vertex[depth-1];
                        w = stk_next[depth-1];
                        while (w < n && !(graph_rows[v][w] && !seen[w]))
                            w++;
                        if (w < n && found.size() < 64 && depth < 64)
                        begin
                            stk_next[depth-1] = w + 1;
                            seen[w] = 1'b1;
                            one.vertex = w[5:0];
                            found.push_back(one);
                            stk_vertex[depth] = w[5:0];
                            stk_next[depth] = 0;
                            depth++;
                        end
                        else
                        begin
                            depth--;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (graph_rows[i])
                    graph_rows[i] = '0;
                one.kind = KIND_CLEARED;
                found.push_back(one);
            end
            default:
            begin
            end
        endcase
        if (found.size() > 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[i])
            awaited_rsp.push_back(found[i]);
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly in range; now and then any vertex at all.
    function automatic logic [5:0] pick_vertex(input int unsigned n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, n - 1));
    endfunction

    task automatic add_item(input logic [OP_W-1:0] op, input logic [5:0] a,
                            input logic [5:0] b, input bit drain);
        backlog_entry_t e;
        e.item.op = op;
        e.item.vertex_a = a;
        e.item.vertex_b = b;
        e.drain_first = drain;
        req_backlog.push_back(e);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (req_backlog.size() > 0 || req_valid || awaited_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic fill_random(input logic [COUNT_W-1:0] raw_count, input bit full_chain,
                               input int unsigned quota);
        int unsigned n;
        int unsigned made;
        int unsigned pick;
        int unsigned len;
        int unsigned j;
        int          order[64];
        int          tmp;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [5:0]  head;
        n = (raw_count > 64) ? 64 : raw_count;
        made = 0;
        if (full_chain)
        begin
            // a path through every vertex in shuffled order: deepest stack, most results
            foreach (order[i])
                order[i] = i;
            for (int i = 63; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 1; i < 64; i++)
                add_item(OP_EDGE, 6'(order[i-1]), 6'(order[i]), 1'b0);
            add_item(OP_DFS, 6'(order[0]), 6'($urandom_range(0, 63)), 1'b0);
            made = 64;
        end
        while (made < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(2, 8);
                repeat (len)
                    add_item(OP_EDGE, pick_vertex(n), pick_vertex(n), 1'b0);
                add_item(OP_DFS, pick_vertex(n), 6'($urandom_range(0, 63)),
                         $urandom_range(0, 9) == 0);
                made += len + 1;
            end
            else if (pick < 70)
            begin
                len = $urandom_range(3, 12);
                head = pick_vertex(n);
                a = head;
                repeat (len)
                begin
                    b = pick_vertex(n);
                    add_item(OP_EDGE, a, b, 1'b0);
                    a = b;
                end
                add_item(OP_DFS, head, 6'($urandom_range(0, 63)), 1'b0);
                made += len + 1;
            end
            else if (pick < 78)
            begin
                add_item(OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         1'b0);
                made++;
            end
            else if (pick < 83)
            begin
                add_item(OP_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         1'b0);
            end
            else
            begin
                add_item($urandom_range(0, 1) ? OP_DFS : OP_EDGE, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)), 1'b0);
                made++;
            end
        end
    endtask

    // Sender: payload and valid change on the falling edge only.
    always @(negedge clk)
    begin : drive_req
        logic      nxt_valid;
        req_item_t nxt_req;
        nxt_valid = req_valid;
        nxt_req = req;
        if (rst_n)
        begin
            if (req_valid && req_fired)
                nxt_valid = 1'b0;
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (req_backlog.size() > 0 &&
                         !(req_backlog[0].drain_first && awaited_rsp.size() > 0))
                begin
                    nxt_req = req_backlog[0].item;
                    nxt_valid = 1'b1;
                    void'(req_backlog.pop_front());
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_gap = pick_gap(send_calm);
                end
            end
        end
        req_valid <= nxt_valid;
        req <= nxt_req;
    end

    // Receiver stall
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 59) == 0)
                recv_calm = !recv_calm;
            if (!recv_calm && $urandom_range(0, 2) == 0)
                stall_left = pick_gap(1'b0);
        end
    end

    always @(posedge clk)
    begin : watch
        rsp_item_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("adjacency_matrix_dfs: mismatch");
            $finish;
        end
        else
        begin
            req_fired <= rst_n && req_valid && !req_stall;
            if (rst_n)
            begin
                if (cfg_we)
                    vertex_limit = cfg_data;
                if (rsp_valid && !rsp_stall)
                begin
                    if (awaited_rsp.size() == 0)
                    begin
                        mismatches++;
                        $display("%0t: unexpected result kind=%0d vertex=%0d last=%0d",
                                 $time, rsp.kind, rsp.vertex, rsp.last);
                    end
                    else
                    begin
                        want = awaited_rsp.pop_front();
                        if (rsp.kind !== want.kind || rsp.vertex !== want.vertex ||
                            rsp.last !== want.last)
                        begin
                            mismatches++;
                            $write("%0t: expected kind=%0d vertex=%0d last=%0d",
                                   $time, want.kind, want.vertex, want.last);
                            $display(", got kind=%0d vertex=%0d last=%0d",
                                     rsp.kind, rsp.vertex, rsp.last);
                        end
                    end
                end
                if (req_valid && !req_stall)
                    walk_graph(req);
            end
        end
    end

    initial
    begin
        foreach (graph_rows[i])
            graph_rows[i] = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // vertex count still at its reset value of zero: everything out of range
        add_item(OP_EDGE, 6'd0, 6'd0, 1'b0);
        add_item(OP_DFS, 6'd0, 6'd0, 1'b0);
        add_item(OP_CLEAR, 6'd0, 6'd0, 1'b0);
        add_item(OP_UNUSED, 6'd63, 6'd63, 1'b0);
        add_item(OP_EDGE, 6'd63, 6'd63, 1'b0);
        wait_idle();

        // oversized count acts as the full 64
        write_count(7'd127);
        add_item(OP_EDGE, 6'd0, 6'd63, 1'b0);
        add_item(OP_EDGE, 6'd63, 6'd63, 1'b0);
        add_item(OP_EDGE, 6'd0, 6'd1, 1'b0);
        add_item(OP_DFS, 6'd63, 6'd0, 1'b1);
        add_item(OP_EDGE, 6'd62, 6'd61, 1'b0);
        add_item(OP_DFS, 6'd62, 6'd63, 1'b0);
        add_item(OP_DFS, 6'd5, 6'd0, 1'b0);
        wait_idle();

        // shrink the count: stored edges at high vertices must not be walked
        write_count(7'd2);
        add_item(OP_DFS, 6'd0, 6'd0, 1'b0);
        add_item(OP_EDGE, 6'd1, 6'd2, 1'b0);
        add_item(OP_EDGE, 6'd2, 6'd0, 1'b0);
        add_item(OP_DFS, 6'd2, 6'd0, 1'b0);
        add_item(OP_DFS, 6'd1, 6'd0, 1'b0);
        add_item(OP_EDGE, 6'd1, 6'd1, 1'b0);
        add_item(OP_DFS, 6'd1, 6'd0, 1'b0);
        wait_idle();

        write_count(7'd1);
        add_item(OP_DFS, 6'd0, 6'd0, 1'b0);
        add_item(OP_EDGE, 6'd0, 6'd0, 1'b0);
        add_item(OP_DFS, 6'd0, 6'd0, 1'b0);
        add_item(OP_CLEAR, 6'd0, 6'd0, 1'b1);
        add_item(OP_DFS, 6'd0, 6'd0, 1'b0);
        wait_idle();

        write_count(7'd64);
        add_item(OP_CLEAR, 6'd0, 6'd0, 1'b0);
        fill_random(7'd64, 1'b1, 64);
        wait_idle();

        write_count(7'($urandom_range(3, 40)));
        fill_random(vertex_limit, 1'b0, 6);
        wait_idle();

        write_count(7'd127);
        fill_random(7'd127, 1'b0, 6);
        wait_idle();

        write_count(7'($urandom_range(41, 63)));
        fill_random(vertex_limit, 1'b0, 6);
        wait_idle();

        if (mismatches == 0)
            $display("adjacency_matrix_dfs: match");
        else
            $display("adjacency_matrix_dfs: mismatch");
        $finish;
    end

endmodule
